### rtl/ctsq_pkg.sv
// ctsq_pkg: shared types, widths and constants of the CAN transmit slot queue
// used by every module of the block but ctsq_ram; depends on nothing
`default_nettype none

package ctsq_pkg;

    localparam int SLOT_COUNT_DEF = 32;
    localparam int ID_W           = 11;
    localparam int LEN_W          = 4;
    localparam int BYTES_W        = 64;
    localparam int WORD_W         = 16;
    localparam int CFG_W          = 4;
    localparam int PEND_W         = 6;

    localparam logic [CFG_W-1:0] FPS_RESET = 4'd3;
    localparam logic [CFG_W-1:0] MAX_DRAIN = 4'd8;

    typedef enum logic [1:0] {
        KIND_ACCEPTED = 2'd0,
        KIND_FULL     = 2'd1,
        KIND_ZERO_ID  = 2'd2,
        KIND_EMIT     = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_SCAN,
        ST_ADD_RES,
        ST_DRAIN_SCAN,
        ST_DRAIN_WRAP,
        ST_DRAIN_READ,
        ST_DRAIN_END
    } state_t;

    typedef struct packed {
        logic accept;
        logic add_next;
        logic add_store;
        logic add_full;
        logic push_add;
        logic rp_next;
        logic take;
        logic att_dec;
        logic capture;
        logic flush;
    } ctsq_cmd_t;

    typedef struct packed {
        logic in_add;
        logic in_id_zero;
        logic fps_zero;
        logic occ_pos;
        logic tries_last;
        logic occ_rp;
        logic rp_last;
        logic att_last;
        logic hold_valid;
        logic out_free;
    } ctsq_status_t;

endpackage

`default_nettype wire

### rtl/ctsq_ram.sv
// ctsq_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module ctsq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/ctsq_datapath.sv
// ctsq_datapath: slot occupancy flags, slot ram, pointers, counters, hold and output registers
// depends on ctsq_pkg and ctsq_ram
`default_nettype none

module ctsq_datapath #(
    parameter int SLOT_COUNT = ctsq_pkg::SLOT_COUNT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ctsq_pkg::ctsq_cmd_t                 cmd,
    output ctsq_pkg::ctsq_status_t              status,
    input  logic                                operation,
    input  logic [ctsq_pkg::ID_W-1:0]           frame_id,
    input  logic [ctsq_pkg::LEN_W-1:0]          frame_len,
    input  logic [ctsq_pkg::WORD_W-1:0]         word0,
    input  logic [ctsq_pkg::WORD_W-1:0]         word1,
    input  logic [ctsq_pkg::WORD_W-1:0]         word2,
    input  logic [ctsq_pkg::WORD_W-1:0]         word3,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ctsq_pkg::CFG_W-1:0]          cfg_data,
    output logic                                result_valid,
    input  logic                                result_stall,
    output ctsq_pkg::kind_t                     kind,
    output logic [ctsq_pkg::ID_W-1:0]           out_id,
    output logic [ctsq_pkg::LEN_W-1:0]          out_len,
    output logic [ctsq_pkg::BYTES_W-1:0]        out_bytes,
    output logic                                last,
    output logic [ctsq_pkg::PEND_W-1:0]         pending
);

    import ctsq_pkg::*;

    localparam int AW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam int PW = (CW > PEND_W) ? CW : PEND_W;
    localparam int EW = ID_W + LEN_W + BYTES_W;
    localparam logic [AW-1:0] LAST_SLOT = AW'(SLOT_COUNT - 1);

    // control state
    logic [CFG_W-1:0]      fps_reg, fps_next;
    logic [AW-1:0]         rp_reg, rp_next;
    logic [AW-1:0]         pos_reg, pos_next;
    logic [AW-1:0]         tries_reg, tries_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CFG_W-1:0]      att_reg, att_next;
    logic [SLOT_COUNT-1:0] occ_reg, occ_next;
    logic                  hold_valid_reg, hold_valid_next;
    logic                  out_valid_reg, out_valid_next;

    // payload
    kind_t                 add_kind_reg, add_kind_next;
    logic [ID_W-1:0]       id_reg, id_next;
    logic [LEN_W-1:0]      len_reg, len_next;
    logic [BYTES_W-1:0]    data_reg, data_next;
    logic [ID_W-1:0]       hold_id_reg, hold_id_next;
    logic [LEN_W-1:0]      hold_len_reg, hold_len_next;
    logic [BYTES_W-1:0]    hold_bytes_reg, hold_bytes_next;
    logic [PEND_W-1:0]     hold_pend_reg, hold_pend_next;
    kind_t                 out_kind_reg, out_kind_next;
    logic [ID_W-1:0]       out_id_reg, out_id_next;
    logic [LEN_W-1:0]      out_len_reg, out_len_next;
    logic [BYTES_W-1:0]    out_bytes_reg, out_bytes_next;
    logic                  out_last_reg, out_last_next;
    logic [PEND_W-1:0]     out_pend_reg, out_pend_next;

    logic [AW-1:0]         rp_inc;
    logic [AW-1:0]         pos_inc;
    logic [PW-1:0]         count_ext;
    logic [EW-1:0]         ram_wr_data;
    logic [EW-1:0]         ram_rd_data;

    ctsq_ram #(
        .WIDTH (EW),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (cmd.add_store),
        .wr_addr (pos_reg),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.take),
        .rd_addr (rp_reg),
        .rd_data (ram_rd_data)
    );

    assign ram_wr_data = {id_reg, len_reg, data_reg};
    assign rp_inc      = (rp_reg == LAST_SLOT) ? '0 : rp_reg + 1'b1;
    assign pos_inc     = (pos_reg == LAST_SLOT) ? '0 : pos_reg + 1'b1;
    assign count_ext   = PW'(count_reg);

    always_comb
    begin
        status.in_add     = (operation == 1'b0);
        status.in_id_zero = (frame_id == '0);
        status.fps_zero   = (fps_reg == '0);
        status.occ_pos    = occ_reg[pos_reg];
        status.tries_last = (tries_reg == LAST_SLOT);
        status.occ_rp     = occ_reg[rp_reg];
        status.rp_last    = (rp_reg == LAST_SLOT);
        status.att_last   = (att_reg == CFG_W'(1));
        status.hold_valid = hold_valid_reg;
        status.out_free   = !out_valid_reg || !result_stall;
    end

    always_comb
    begin
        fps_next        = fps_reg;
        rp_next         = rp_reg;
        pos_next        = pos_reg;
        tries_next      = tries_reg;
        count_next      = count_reg;
        att_next        = att_reg;
        occ_next        = occ_reg;
        hold_valid_next = hold_valid_reg;
        out_valid_next  = out_valid_reg && result_stall;
        add_kind_next   = add_kind_reg;
        id_next         = id_reg;
        len_next        = len_reg;
        data_next       = data_reg;
        hold_id_next    = hold_id_reg;
        hold_len_next   = hold_len_reg;
        hold_bytes_next = hold_bytes_reg;
        hold_pend_next  = hold_pend_reg;
        out_kind_next   = out_kind_reg;
        out_id_next     = out_id_reg;
        out_len_next    = out_len_reg;
        out_bytes_next  = out_bytes_reg;
        out_last_next   = out_last_reg;
        out_pend_next   = out_pend_reg;

        if (cfg_valid)
        begin
            fps_next = cfg_data;
        end

        if (cmd.accept)
        begin
            id_next       = frame_id;
            len_next      = frame_len;
            data_next     = {word0, word1, word2, word3};
            add_kind_next = KIND_ZERO_ID;
            pos_next      = rp_inc;
            tries_next    = '0;
            att_next      = (fps_reg > MAX_DRAIN) ? MAX_DRAIN : fps_reg;
        end

        if (cmd.add_next)
        begin
            pos_next   = pos_inc;
            tries_next = tries_reg + 1'b1;
        end

        if (cmd.add_store)
        begin
            occ_next[pos_reg] = 1'b1;
            count_next        = count_reg + 1'b1;
            add_kind_next     = KIND_ACCEPTED;
        end

        if (cmd.add_full)
        begin
            add_kind_next = KIND_FULL;
        end

        if (cmd.push_add)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = add_kind_reg;
            out_id_next    = '0;
            out_len_next   = '0;
            out_bytes_next = '0;
            out_last_next  = 1'b1;
            out_pend_next  = count_ext[PEND_W-1:0];
        end

        if (cmd.rp_next)
        begin
            rp_next = rp_inc;
        end

        if (cmd.take)
        begin
            occ_next[rp_reg] = 1'b0;
            if (count_reg != '0)
            begin
                count_next = count_reg - 1'b1;
            end
        end

        if (cmd.att_dec)
        begin
            att_next = att_reg - 1'b1;
        end

        if (cmd.capture)
        begin
            if (hold_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_kind_next  = KIND_EMIT;
                out_id_next    = hold_id_reg;
                out_len_next   = hold_len_reg;
                out_bytes_next = hold_bytes_reg;
                out_last_next  = 1'b0;
                out_pend_next  = hold_pend_reg;
            end
            hold_valid_next = 1'b1;
            hold_id_next    = ram_rd_data[EW-1 -: ID_W];
            hold_len_next   = ram_rd_data[BYTES_W +: LEN_W];
            hold_bytes_next = ram_rd_data[BYTES_W-1:0];
            hold_pend_next  = count_ext[PEND_W-1:0];
        end

        if (cmd.flush)
        begin
            hold_valid_next = 1'b0;
            out_valid_next  = 1'b1;
            out_kind_next   = KIND_EMIT;
            out_id_next     = hold_id_reg;
            out_len_next    = hold_len_reg;
            out_bytes_next  = hold_bytes_reg;
            out_last_next   = 1'b1;
            out_pend_next   = hold_pend_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fps_reg        <= FPS_RESET;
            rp_reg         <= '0;
            pos_reg        <= '0;
            tries_reg      <= '0;
            count_reg      <= '0;
            att_reg        <= '0;
            occ_reg        <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            fps_reg        <= fps_next;
            rp_reg         <= rp_next;
            pos_reg        <= pos_next;
            tries_reg      <= tries_next;
            count_reg      <= count_next;
            att_reg        <= att_next;
            occ_reg        <= occ_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        add_kind_reg   <= add_kind_next;
        id_reg         <= id_next;
        len_reg        <= len_next;
        data_reg       <= data_next;
        hold_id_reg    <= hold_id_next;
        hold_len_reg   <= hold_len_next;
        hold_bytes_reg <= hold_bytes_next;
        hold_pend_reg  <= hold_pend_next;
        out_kind_reg   <= out_kind_next;
        out_id_reg     <= out_id_next;
        out_len_reg    <= out_len_next;
        out_bytes_reg  <= out_bytes_next;
        out_last_reg   <= out_last_next;
        out_pend_reg   <= out_pend_next;
    end

    assign cfg_ready    = 1'b1;
    assign result_valid = out_valid_reg;
    assign kind         = out_kind_reg;
    assign out_id       = out_id_reg;
    assign out_len      = out_len_reg;
    assign out_bytes    = out_bytes_reg;
    assign last         = out_last_reg;
    assign pending      = out_pend_reg;

endmodule

`default_nettype wire

### rtl/ctsq_ctrl.sv
// ctsq_ctrl: sequencer for add scans and drain attempts
// depends on ctsq_pkg
`default_nettype none

module ctsq_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  ctsq_pkg::ctsq_status_t status,
    output ctsq_pkg::ctsq_cmd_t    cmd
);

    import ctsq_pkg::*;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (status.in_add)
                    begin
                        state_next = status.in_id_zero ? ST_ADD_RES : ST_ADD_SCAN;
                    end
                    else if (!status.fps_zero)
                    begin
                        state_next = ST_DRAIN_SCAN;
                    end
                end
            end
            ST_ADD_SCAN:
            begin
                if (!status.occ_pos || status.tries_last)
                begin
                    state_next = ST_ADD_RES;
                end
            end
            ST_ADD_RES:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DRAIN_SCAN:
            begin
                if (status.occ_rp)
                begin
                    state_next = ST_DRAIN_READ;
                end
                else if (status.rp_last)
                begin
                    state_next = ST_DRAIN_WRAP;
                end
            end
            ST_DRAIN_WRAP:
            begin
                if (status.occ_rp)
                begin
                    state_next = ST_DRAIN_READ;
                end
                else
                begin
                    state_next = status.att_last ? ST_DRAIN_END : ST_DRAIN_SCAN;
                end
            end
            ST_DRAIN_READ:
            begin
                if (!status.hold_valid || status.out_free)
                begin
                    state_next = status.att_last ? ST_DRAIN_END : ST_DRAIN_SCAN;
                end
            end
            ST_DRAIN_END:
            begin
                if (!status.hold_valid || status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        item_stall = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = item_valid;
            end
            ST_ADD_SCAN:
            begin
                if (!status.occ_pos)
                begin
                    cmd.add_store = 1'b1;
                end
                else if (status.tries_last)
                begin
                    cmd.add_full = 1'b1;
                end
                else
                begin
                    cmd.add_next = 1'b1;
                end
            end
            ST_ADD_RES:
            begin
                cmd.push_add = status.out_free;
            end
            ST_DRAIN_SCAN:
            begin
                if (status.occ_rp)
                begin
                    cmd.take = 1'b1;
                end
                else
                begin
                    cmd.rp_next = 1'b1;
                end
            end
            ST_DRAIN_WRAP:
            begin
                if (status.occ_rp)
                begin
                    cmd.take = 1'b1;
                end
                else
                begin
                    cmd.att_dec = 1'b1;
                end
            end
            ST_DRAIN_READ:
            begin
                if (!status.hold_valid || status.out_free)
                begin
                    cmd.capture = 1'b1;
                    cmd.att_dec = 1'b1;
                end
            end
            ST_DRAIN_END:
            begin
                cmd.flush = status.hold_valid && status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### rtl/can_tx_slot_queue.sv
// can_tx_slot_queue: top level of the CAN transmit slot queue
// depends on ctsq_pkg, ctsq_ctrl and ctsq_datapath
//
// Queues standard CAN transmit requests in SLOT_COUNT slots held in one ram, with one
// occupancy flag per slot in flip-flops, so the table is empty right after reset with no
// clearing pass. An add item looks one slot per cycle for a free slot starting after the
// read pointer; a zero identifier is answered with no scan. A service item makes
// min(frames_per_service, 8) drain attempts; each attempt scans the occupancy flags one
// slot per cycle up to the table end, then slot 0, and a found frame also needs a ram
// read before it is held. A service item with frames_per_service 0 makes no drain
// attempt. The final frame of a service item is held back one step so that it can
// carry last. One item is worked on at a time; item_stall is high after acceptance
// until the item's last result, if it has one, is loaded into the output register,
// and stays low for a service item with frames_per_service 0. cfg_ready is always
// high; write frames_per_service only while the block is idle.
`default_nettype none

module can_tx_slot_queue #(
    parameter int SLOT_COUNT = ctsq_pkg::SLOT_COUNT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic                          operation,
    input  logic [ctsq_pkg::ID_W-1:0]     frame_id,
    input  logic [ctsq_pkg::LEN_W-1:0]    frame_len,
    input  logic [ctsq_pkg::WORD_W-1:0]   word0,
    input  logic [ctsq_pkg::WORD_W-1:0]   word1,
    input  logic [ctsq_pkg::WORD_W-1:0]   word2,
    input  logic [ctsq_pkg::WORD_W-1:0]   word3,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ctsq_pkg::CFG_W-1:0]    cfg_data,
    output logic                          result_valid,
    input  logic                          result_stall,
    output ctsq_pkg::kind_t               kind,
    output logic [ctsq_pkg::ID_W-1:0]     out_id,
    output logic [ctsq_pkg::LEN_W-1:0]    out_len,
    output logic [ctsq_pkg::BYTES_W-1:0]  out_bytes,
    output logic                          last,
    output logic [ctsq_pkg::PEND_W-1:0]   pending
);

    import ctsq_pkg::*;

    ctsq_cmd_t    cmd;
    ctsq_status_t status;

    ctsq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    ctsq_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .operation    (operation),
        .frame_id     (frame_id),
        .frame_len    (frame_len),
        .word0        (word0),
        .word1        (word1),
        .word2        (word2),
        .word3        (word3),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .kind         (kind),
        .out_id       (out_id),
        .out_len      (out_len),
        .out_bytes    (out_bytes),
        .last         (last),
        .pending      (pending)
    );

`ifndef SYNTH
    // add results always close their item
    a_add_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && kind != KIND_EMIT) |-> last)
        else $error("add result without last");

    // an emitted frame never carries the empty identifier
    a_emit_id: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && kind == KIND_EMIT) |-> (out_id != '0))
        else $error("emitted frame with zero identifier");

    // an accepted add beat keeps the input stalled on the next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall && !operation) |=> item_stall)
        else $error("input not stalled after accept");

    // add results never carry frame data
    a_add_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && kind != KIND_EMIT) |-> (out_id == '0 && out_len == '0))
        else $error("add result with frame fields");
`endif

endmodule

`default_nettype wire

### bench/tb_can_tx_slot_queue.sv
// tb_can_tx_slot_queue: self-checking bench for the CAN transmit slot queue, with a queue-fed
// driver, a result monitor checked against a slot table predictor, and random idling
// depends on ctsq_pkg and can_tx_slot_queue
`timescale 1ns / 1ps

module tb_can_tx_slot_queue;

    import ctsq_pkg::*;

    localparam int SLOTS        = SLOT_COUNT_DEF;
    localparam int DRAIN_CYCLES = 8 * (SLOTS + 2) + 20;
    localparam int HOLD_CYCLES  = 400;
    localparam logic OP_ADD     = 1'b0;
    localparam logic OP_SERVICE = 1'b1;

    typedef struct packed {
        logic              op;
        logic [ID_W-1:0]   id;
        logic [LEN_W-1:0]  len;
        logic [WORD_W-1:0] w0;
        logic [WORD_W-1:0] w1;
        logic [WORD_W-1:0] w2;
        logic [WORD_W-1:0] w3;
    } tx_req_t;

    typedef struct packed {
        kind_t              kind;
        logic [ID_W-1:0]    id;
        logic [LEN_W-1:0]   len;
        logic [BYTES_W-1:0] bytes;
        logic               last;
        logic [PEND_W-1:0]  pend;
    } tx_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               item_valid = 1'b0;
    logic               item_stall;
    tx_req_t            offered = '0;
    logic               operation;
    logic [ID_W-1:0]    frame_id;
    logic [LEN_W-1:0]   frame_len;
    logic [WORD_W-1:0]  word0;
    logic [WORD_W-1:0]  word1;
    logic [WORD_W-1:0]  word2;
    logic [WORD_W-1:0]  word3;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CFG_W-1:0]   cfg_data = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    kind_t              kind;
    logic [ID_W-1:0]    out_id;
    logic [LEN_W-1:0]   out_len;
    logic [BYTES_W-1:0] out_bytes;
    logic               last;
    logic [PEND_W-1:0]  pending;

    tx_req_t            pending_reqs[$];
    tx_result_t         expected_frames[$];
    int                 errors = 0;
    int                 send_idle = 0;
    int                 recv_idle = 0;
    logic               hold_go = 1'b0;
    int                 hold_left = 0;

    // predicted slot table
    logic [ID_W-1:0]    tbl_ident[SLOTS];
    logic [LEN_W-1:0]   tbl_len[SLOTS];
    logic [BYTES_W-1:0] tbl_bytes[SLOTS];
    int                 tbl_rp = 0;
    int                 tbl_count = 0;
    logic [CFG_W-1:0]   tbl_fps = FPS_RESET;

    assign operation = offered.op;
    assign frame_id  = offered.id;
    assign frame_len = offered.len;
    assign word0     = offered.w0;
    assign word1     = offered.w1;
    assign word2     = offered.w2;
    assign word3     = offered.w3;

    can_tx_slot_queue dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .operation    (operation),
        .frame_id     (frame_id),
        .frame_len    (frame_len),
        .word0        (word0),
        .word1        (word1),
        .word2        (word2),
        .word3        (word3),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .kind         (kind),
        .out_id       (out_id),
        .out_len      (out_len),
        .out_bytes    (out_bytes),
        .last         (last),
        .pending      (pending)
    );

    always #10 clk = ~clk;

    function automatic tx_req_t make_req(input logic op, input logic [ID_W-1:0] id,
                                         input logic [LEN_W-1:0] len,
                                         input logic [WORD_W-1:0] w0,
                                         input logic [WORD_W-1:0] w1,
                                         input logic [WORD_W-1:0] w2,
                                         input logic [WORD_W-1:0] w3);
        tx_req_t r;
        r.op = op;
        r.id = id;
        r.len = len;
        r.w0 = w0;
        r.w1 = w1;
        r.w2 = w2;
        r.w3 = w3;
        return r;
    endfunction

    function automatic tx_req_t random_add();
        logic [ID_W-1:0]  id;
        logic [LEN_W-1:0] len;
        id  = ($urandom_range(9) == 0) ? '0 : ID_W'($urandom_range(1, 2047));
        len = ($urandom_range(3) == 0) ? LEN_W'($urandom_range(15)) : LEN_W'($urandom_range(8));
        return make_req(OP_ADD, id, len, WORD_W'($urandom()), WORD_W'($urandom()),
                        WORD_W'($urandom()), WORD_W'($urandom()));
    endfunction

    function automatic tx_req_t service_req();
        return make_req(OP_SERVICE, ID_W'($urandom()), LEN_W'($urandom()), WORD_W'($urandom()),
                        WORD_W'($urandom()), WORD_W'($urandom()), WORD_W'($urandom()));
    endfunction

    // works out the results of one accepted beat and updates the predicted table
    task automatic predict_queue(input tx_req_t r);
        int         pos;
        int         tries;
        int         attempts;
        int         a;
        bit         wrapped;
        bit         have_held;
        tx_result_t res;
        tx_result_t held;
        if (tbl_rp >= SLOTS)
            tbl_rp = 0;
        res = '0;
        res.last = 1'b1;
        held = '0;
        have_held = 1'b0;
        if (r.op == OP_ADD)
        begin
            if (r.id == '0)
                res.kind = KIND_ZERO_ID;
            else
            begin
                pos = (tbl_rp + 1) % SLOTS;
                tries = 0;
                while (tries < SLOTS && tbl_ident[pos] != '0)
                begin
                    pos = (pos + 1) % SLOTS;
                    tries++;
                end
                if (tries == SLOTS)
                    res.kind = KIND_FULL;
                else
                begin
                    tbl_ident[pos] = r.id;
                    tbl_len[pos] = r.len;
                    tbl_bytes[pos] = {r.w0, r.w1, r.w2, r.w3};
                    tbl_count++;
                    res.kind = KIND_ACCEPTED;
                end
            end
            res.pend = tbl_count[PEND_W-1:0];
            expected_frames.push_back(res);
        end
        else
        begin
            attempts = (tbl_fps > MAX_DRAIN) ? int'(MAX_DRAIN) : int'(tbl_fps);
            for (a = 0; a < attempts; a++)
            begin
                wrapped = 1'b0;
                while (tbl_ident[tbl_rp] == '0 && !wrapped)
                begin
                    if (tbl_rp == SLOTS - 1)
                    begin
                        tbl_rp = 0;
                        wrapped = 1'b1;
                    end
                    else
                        tbl_rp++;
                end
                if (tbl_ident[tbl_rp] != '0)
                begin
                    if (have_held)
                        expected_frames.push_back(held);
                    held = '0;
                    held.kind = KIND_EMIT;
                    held.id = tbl_ident[tbl_rp];
                    held.len = tbl_len[tbl_rp];
                    held.bytes = tbl_bytes[tbl_rp];
                    tbl_ident[tbl_rp] = '0;
                    tbl_len[tbl_rp] = '0;
                    if (tbl_count > 0)
                        tbl_count--;
                    held.pend = tbl_count[PEND_W-1:0];
                    have_held = 1'b1;
                end
            end
            // final frame of the service carries last
            if (have_held)
            begin
                held.last = 1'b1;
                expected_frames.push_back(held);
            end
        end
    endtask

    always @(posedge clk)
    begin : driver
        tx_req_t nxt;
        if (rst_n)
        begin
            if (item_valid && !item_stall)
                predict_queue(offered);
            if (!item_valid || !item_stall)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle)
                begin
                    nxt = pending_reqs.pop_front();
                    offered <= nxt;
                    item_valid <= 1'b1;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        tx_result_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_frames.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, got kind %0d id %h",
                             $time, kind, out_id);
                    $display("%0t:     len %h bytes %h last %b pending %0d",
                             $time, out_len, out_bytes, last, pending);
                    errors++;
                end
                else
                begin
                    want = expected_frames.pop_front();
                    if (kind !== want.kind || out_id !== want.id || out_len !== want.len ||
                        out_bytes !== want.bytes || last !== want.last || pending !== want.pend)
                    begin
                        $display("%0t: mismatch: expected kind %0d id %h len %h bytes %h",
                                 $time, want.kind, want.id, want.len, want.bytes);
                        $display("%0t:     expected last %b pending %0d",
                                 $time, want.last, want.pend);
                        $display("%0t:     got kind %0d id %h len %h bytes %h",
                                 $time, kind, out_id, out_len, out_bytes);
                        $display("%0t:     got last %b pending %0d",
                                 $time, last, pending);
                        errors++;
                    end
                end
            end
            result_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle);
        end
    end

    // long receiver hold-off
    always @(posedge clk)
    begin
        if (hold_go)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    task automatic set_idling(input int snd, input int rcv);
        @(posedge clk);
        send_idle <= snd;
        recv_idle <= rcv;
    endtask

    task automatic write_fps(input logic [CFG_W-1:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        tbl_fps = v;
    endtask

    // sampled between edges so that the driver's and the block's updates have settled
    task automatic wait_idle();
        @(negedge clk);
        while (pending_reqs.size() != 0 || item_valid || item_stall ||
               expected_frames.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic queue_fill(input int n);
        int i;
        tx_req_t r;
        for (i = 0; i < n; i++)
        begin
            r = random_add();
            if (r.id == '0)
                r.id = ID_W'($urandom_range(1, 2047));
            pending_reqs.push_back(r);
        end
    endtask

    task automatic queue_mix(input int n, input int add_pct);
        int i;
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < add_pct)
                pending_reqs.push_back(random_add());
            else
                pending_reqs.push_back(service_req());
        end
    endtask

    initial
    begin
        for (int s = 0; s < SLOTS; s++)
        begin
            tbl_ident[s] = '0;
            tbl_len[s] = '0;
            tbl_bytes[s] = '0;
        end

        // directed beats under the reset drain setting
        pending_reqs.push_back(make_req(OP_SERVICE, '0, '0, '0, '0, '0, '0));
        pending_reqs.push_back(make_req(OP_ADD, '0, 4'd8,
                                        16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        pending_reqs.push_back(make_req(OP_ADD, 11'h7FF, 4'hF,
                                        16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        pending_reqs.push_back(make_req(OP_ADD, 11'h001, 4'h0,
                                        16'h0000, 16'h0000, 16'h0000, 16'h0000));
        pending_reqs.push_back(make_req(OP_ADD, 11'h555, 4'd8,
                                        16'h0123, 16'h4567, 16'h89AB, 16'hCDEF));
        pending_reqs.push_back(make_req(OP_ADD, 11'h2AA, 4'd9,
                                        16'hAAAA, 16'h5555, 16'hA5A5, 16'h5A5A));
        pending_reqs.push_back(make_req(OP_SERVICE, 11'h7FF, 4'hF,
                                        16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        pending_reqs.push_back(make_req(OP_SERVICE, '0, '0, '0, '0, '0, '0));
        pending_reqs.push_back(make_req(OP_SERVICE, '0, '0, '0, '0, '0, '0));
        pending_reqs.push_back(make_req(OP_ADD, 11'h400, 4'd1,
                                        16'h8000, 16'h0001, 16'h7FFF, 16'hFFFE));
        pending_reqs.push_back(make_req(OP_ADD, 11'h3FF, 4'd7,
                                        16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0));
        pending_reqs.push_back(make_req(OP_SERVICE, '0, '0, '0, '0, '0, '0));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        set_idling(6, 67);
        wait_idle();

        write_fps(4'd15);
        queue_fill(34);
        queue_mix(30, 55);
        wait_idle();

        set_idling(67, 6);
        write_fps(4'd0);
        queue_mix(20, 60);
        wait_idle();

        write_fps(4'd1);
        queue_mix(60, 45);
        wait_idle();

        set_idling(0, 0);
        write_fps(4'd8);
        queue_fill(34);
        queue_mix(30, 50);
        @(posedge clk);
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
        wait_idle();

        write_fps(CFG_W'($urandom_range(2, 7)));
        queue_mix(60, 55);
        wait_idle();

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
